// ===== design/log_frame_deframer_assert.svh =====
// ------------------------------------------------------------------------
// log frame deframer assertion macros
// shared property wrappers, clocked on i_clk and disabled in reset
// ------------------------------------------------------------------------
`ifndef LOG_FRAME_DEFRAMER_ASSERT_SVH
`define LOG_FRAME_DEFRAMER_ASSERT_SVH

// condition holds at every edge out of reset
`define LFD_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// cause implies effect at the same edge
`define LFD_ASSERT_IMPL(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cause) |-> (effect)) \
        else $error(msg);

// cause implies effect at the next edge
`define LFD_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

// ===== design/lfd_pkg.sv =====
// ------------------------------------------------------------------------
// lfd_pkg
// shared types and constants of the log frame deframer
// ------------------------------------------------------------------------
`default_nettype none

package lfd_pkg;

    // variable limit per frame and number of frame ids in use
    localparam int unsigned MAX_VARS    = 32;
    localparam int unsigned FRAME_COUNT = 3;

    // timestamp scale applied on the way out
    localparam int unsigned TIME_SCALE  = 10;

    // configuration port shape
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    // default depth of the queue between parser and output stage
    localparam int unsigned QUEUE_DEPTH = 4;

    // one parsed request on its way to the output stage
    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_number;
        logic [4:0]  var_index;
        logic [31:0] value;
        logic [31:0] time_raw;
        logic        last_of_frame;
    } t_record;

endpackage

`default_nettype wire

// ===== design/log_frame_deframer.sv =====
// ------------------------------------------------------------------------
// log_frame_deframer
// splits a received log byte stream into frame variables
// ------------------------------------------------------------------------
// Takes one byte per clock whenever full is low. Once enabled, the parser
// waits for a 0xFF marker, then reads frames back to back: id byte, 4-byte
// timestamp, then the configured variables of that frame. Every finished
// variable, or an unknown-id error, becomes one result; the parser writes
// it into the queue at the edge that accepts the byte that completes it,
// and the output register loads it from the queue once that register is
// empty or being popped. Sustained rate is one byte per cycle while full
// is low, as the parser handles each accepted byte in one combinational
// step; full only rises when the QUEUE_DEPTH_P-entry queue and the
// output register all hold results that have not been popped. After an
// unknown id the parser drops bytes until log_enable is written again.
// ------------------------------------------------------------------------
`default_nettype none

module log_frame_deframer import lfd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                       empty,
    input  wire logic                  pop,
    output logic                       o_kind,
    output logic [7:0]                 o_frame_number,
    output logic [4:0]                 o_var_index,
    output logic [31:0]                o_value,
    output logic [35:0]                o_timestamp,
    output logic                       o_last_of_frame
);

    logic    w_accept;
    logic    w_rec_valid;
    t_record w_rec;
    logic    w_q_full;
    logic    w_q_empty;
    logic    w_q_rd;
    t_record w_q_data;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    // parser and configuration
    lfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rec_valid (w_rec_valid),
        .o_rec       (w_rec)
    );

    // request queue
    lfd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_rec_valid),
        .i_wr_data (w_rec),
        .o_full    (w_q_full),
        .i_rd_en   (w_q_rd),
        .o_rd_data (w_q_data),
        .o_empty   (w_q_empty)
    );

    // output stage
    lfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .i_q_data        (w_q_data),
        .o_q_rd          (w_q_rd),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_kind          (o_kind),
        .o_frame_number  (o_frame_number),
        .o_var_index     (o_var_index),
        .o_value         (o_value),
        .o_timestamp     (o_timestamp),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

`default_nettype wire

// ===== design/lfd_front.sv =====
// ------------------------------------------------------------------------
// lfd_front
// byte parser: start marker, frame id, timestamp and variable assembly,
// plus the configuration registers it runs from
// ------------------------------------------------------------------------
`default_nettype none
`include "log_frame_deframer_assert.svh"

module lfd_front import lfd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                       o_rec_valid,
    output t_record                    o_rec
);

    // parser phases
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_ID   = 2'd1;
    localparam logic [1:0] PH_TIME = 2'd2;
    localparam logic [1:0] PH_VARS = 2'd3;

    // result kinds
    localparam logic KIND_VAR   = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOG_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_F0_COUNT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_F1_COUNT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_F2_COUNT   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_F0_SIZES   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_F1_SIZES   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_F2_SIZES   = CFG_IDX_W'(6);

    localparam logic [7:0] START_MARK     = 8'hFF;
    localparam int unsigned TIME_BYTES    = 4;
    localparam int unsigned NUM_FRAME_REG = 3;

    // counts above the variable limit act as the limit
    function automatic logic [5:0] clamp_count(input logic [5:0] raw);
        return (raw > 6'(MAX_VARS)) ? 6'(MAX_VARS) : raw;
    endfunction

    logic        r_enable,   n_enable;
    logic        r_halted,   n_halted;
    logic [1:0]  r_phase,    n_phase;
    logic [1:0]  r_byte_cnt, n_byte_cnt;
    logic [4:0]  r_var_pos,  n_var_pos;
    logic [1:0]  r_frame,    n_frame;
    logic [31:0] r_time,     n_time;
    logic [31:0] r_value,    n_value;
    logic [5:0]  r_var_count [NUM_FRAME_REG];
    logic [5:0]  n_var_count [NUM_FRAME_REG];
    logic [63:0] r_sizes     [NUM_FRAME_REG];
    logic [63:0] n_sizes     [NUM_FRAME_REG];

    logic [5:0]  w_id_raw;
    logic [5:0]  w_id_count;
    logic        w_id_ok;
    logic [5:0]  w_cur_raw;
    logic [5:0]  w_cur_count;
    logic [63:0] w_cur_sizes;
    logic [1:0]  w_size_code;
    logic        w_var_done;
    logic        w_last;
    logic [31:0] w_value_acc;

    // variable count of the incoming id byte
    always_comb begin
        case (i_rx_byte[1:0])
            2'd0:    w_id_raw = r_var_count[0];
            2'd1:    w_id_raw = r_var_count[1];
            2'd2:    w_id_raw = r_var_count[2];
            default: w_id_raw = 6'd0;
        endcase
    end

    assign w_id_count = clamp_count(w_id_raw);
    assign w_id_ok    = (i_rx_byte < 8'(FRAME_COUNT)) && (w_id_count != 6'd0);

    // count and size word of the active frame
    always_comb begin
        case (r_frame)
            2'd0: begin
                w_cur_raw   = r_var_count[0];
                w_cur_sizes = r_sizes[0];
            end
            2'd1: begin
                w_cur_raw   = r_var_count[1];
                w_cur_sizes = r_sizes[1];
            end
            2'd2: begin
                w_cur_raw   = r_var_count[2];
                w_cur_sizes = r_sizes[2];
            end
            default: begin
                w_cur_raw   = 6'd0;
                w_cur_sizes = 64'd0;
            end
        endcase
    end

    assign w_cur_count = clamp_count(w_cur_raw);
    assign w_size_code = w_cur_sizes[{r_var_pos, 1'b0} +: 2];
    assign w_var_done  = (r_byte_cnt == w_size_code);
    assign w_last      = (({1'b0, r_var_pos} + 6'd1) >= w_cur_count);

    // first byte of a variable starts from zero
    assign w_value_acc = {((r_byte_cnt == 2'd0) ? 24'd0 : r_value[23:0]), i_rx_byte};

    // parser step and configuration writes
    always_comb begin
        n_enable    = r_enable;
        n_halted    = r_halted;
        n_phase     = r_phase;
        n_byte_cnt  = r_byte_cnt;
        n_var_pos   = r_var_pos;
        n_frame     = r_frame;
        n_time      = r_time;
        n_value     = r_value;
        n_var_count = r_var_count;
        n_sizes     = r_sizes;
        o_rec_valid = 1'b0;
        o_rec       = '0;

        if (i_accept) begin
            if (!r_enable || r_halted) begin
                n_phase    = PH_WAIT;
                n_byte_cnt = 2'd0;
                n_var_pos  = 5'd0;
                n_value    = 32'd0;
            end else begin
                case (r_phase)
                    PH_WAIT: begin
                        if (i_rx_byte == START_MARK) begin
                            n_phase = PH_ID;
                        end
                    end
                    PH_ID: begin
                        if (!w_id_ok) begin
                            // unknown id: report it and stop until re-enabled
                            o_rec_valid        = 1'b1;
                            o_rec.kind         = KIND_ERROR;
                            o_rec.frame_number = i_rx_byte;
                            n_phase            = PH_WAIT;
                            n_byte_cnt         = 2'd0;
                            n_var_pos          = 5'd0;
                            n_value            = 32'd0;
                            n_halted           = 1'b1;
                        end else begin
                            n_frame    = i_rx_byte[1:0];
                            n_time     = 32'd0;
                            n_byte_cnt = 2'd0;
                            n_phase    = PH_TIME;
                        end
                    end
                    PH_TIME: begin
                        n_time     = {r_time[23:0], i_rx_byte};
                        n_byte_cnt = r_byte_cnt + 2'd1;
                        if (r_byte_cnt == 2'(TIME_BYTES - 1)) begin
                            n_phase   = PH_VARS;
                            n_var_pos = 5'd0;
                            n_value   = 32'd0;
                        end
                    end
                    PH_VARS: begin
                        n_value    = w_value_acc;
                        n_byte_cnt = r_byte_cnt + 2'd1;
                        if (w_var_done) begin
                            o_rec_valid         = 1'b1;
                            o_rec.kind          = KIND_VAR;
                            o_rec.frame_number  = {6'd0, r_frame};
                            o_rec.var_index     = r_var_pos;
                            o_rec.value         = w_value_acc;
                            o_rec.time_raw      = r_time;
                            o_rec.last_of_frame = w_last;
                            n_byte_cnt          = 2'd0;
                            if (w_last) begin
                                n_phase   = PH_ID;
                                n_var_pos = 5'd0;
                            end else begin
                                n_var_pos = r_var_pos + 5'd1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_WAIT;
                    end
                endcase
            end
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOG_ENABLE: begin
                    n_enable = i_cfg_wdata[0];
                    n_halted = 1'b0;
                    if (!i_cfg_wdata[0]) begin
                        n_phase    = PH_WAIT;
                        n_byte_cnt = 2'd0;
                        n_var_pos  = 5'd0;
                        n_value    = 32'd0;
                    end
                end
                REG_F0_COUNT: n_var_count[0] = i_cfg_wdata[5:0];
                REG_F1_COUNT: n_var_count[1] = i_cfg_wdata[5:0];
                REG_F2_COUNT: n_var_count[2] = i_cfg_wdata[5:0];
                REG_F0_SIZES: n_sizes[0]     = i_cfg_wdata[63:0];
                REG_F1_SIZES: n_sizes[1]     = i_cfg_wdata[63:0];
                REG_F2_SIZES: n_sizes[2]     = i_cfg_wdata[63:0];
                default: begin
                end
            endcase
        end
    end

    // parser and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_halted    <= 1'b0;
            r_phase     <= PH_WAIT;
            r_byte_cnt  <= 2'd0;
            r_var_pos   <= 5'd0;
            r_frame     <= 2'd0;
            r_var_count <= '{default: 6'd0};
            r_sizes     <= '{default: 64'd0};
        end else begin
            r_enable    <= n_enable;
            r_halted    <= n_halted;
            r_phase     <= n_phase;
            r_byte_cnt  <= n_byte_cnt;
            r_var_pos   <= n_var_pos;
            r_frame     <= n_frame;
            r_var_count <= n_var_count;
            r_sizes     <= n_sizes;
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        r_time  <= n_time;
        r_value <= n_value;
    end

    `LFD_ASSERT(a_halt_parked, (!r_halted || (r_phase == PH_WAIT && r_byte_cnt == 2'd0)), "halted parser not parked")
    `LFD_ASSERT_NEXT(a_error_halts, (o_rec_valid && o_rec.kind == KIND_ERROR && !i_cfg_we), r_halted, "unknown id did not halt")

endmodule

`default_nettype wire

// ===== design/lfd_queue.sv =====
// ------------------------------------------------------------------------
// lfd_queue
// short request queue between the parser and the output stage
// ------------------------------------------------------------------------
`default_nettype none
`include "log_frame_deframer_assert.svh"

module lfd_queue import lfd_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH   // 2 or more
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr_en,
    input  wire t_record i_wr_data,
    output logic         o_full,
    input  wire logic    i_rd_en,
    output t_record      o_rd_data,
    output logic         o_empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_record            r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == CNT_W'(0));
    assign o_rd_data = r_slot[r_rd_ptr];

    // pointer wrap and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_wr_ptr + PTR_W'(1);
        end
        if (i_rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_rd_ptr + PTR_W'(1);
        end
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

    `LFD_ASSERT(a_count_bound, (r_count <= CNT_W'(DEPTH)), "queue count beyond depth")
    `LFD_ASSERT_IMPL(a_no_overflow, i_wr_en, !o_full, "request written into full queue")

endmodule

`default_nettype wire

// ===== design/lfd_back.sv =====
// ------------------------------------------------------------------------
// lfd_back
// output stage: scales the timestamp and holds the oldest result
// ------------------------------------------------------------------------
`default_nettype none

module lfd_back import lfd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_empty,
    input  wire t_record i_q_data,
    output logic         o_q_rd,
    output logic         o_empty,
    input  wire logic    i_pop,
    output logic         o_kind,
    output logic [7:0]   o_frame_number,
    output logic [4:0]   o_var_index,
    output logic [31:0]  o_value,
    output logic [35:0]  o_timestamp,
    output logic         o_last_of_frame
);

    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_frame_number;
    logic [4:0]  r_var_index;
    logic [31:0] r_value;
    logic [35:0] r_timestamp;
    logic        r_last;
    logic        w_take;

    // refill when the slot is free or being taken
    assign w_take = i_pop && r_valid;
    assign o_q_rd = !i_q_empty && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (w_take) begin
            r_valid <= 1'b0;
        end
    end

    // result payload, timestamp times ten on load
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_kind         <= i_q_data.kind;
            r_frame_number <= i_q_data.frame_number;
            r_var_index    <= i_q_data.var_index;
            r_value        <= i_q_data.value;
            r_timestamp    <= 36'(i_q_data.time_raw) * 36'(TIME_SCALE);
            r_last         <= i_q_data.last_of_frame;
        end
    end

    assign o_empty         = !r_valid;
    assign o_kind          = r_kind;
    assign o_frame_number  = r_frame_number;
    assign o_var_index     = r_var_index;
    assign o_value         = r_value;
    assign o_timestamp     = r_timestamp;
    assign o_last_of_frame = r_last;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// tb_top: log frame deframer testbench
// feeds byte streams of framed log data through the push/full side, keeps
// a cycle-free model of the parser to predict every variable and bad-id
// result, and checks each popped result field by field against it
// ------------------------------------------------------------------------

module tb_top;
    import lfd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 525;
    localparam int HOLD_CYCLES   = 200;

    // idle percentages for the two sides
    localparam int IDLE_LO = 34;
    localparam int IDLE_HI = 63;

    localparam logic [7:0] START_MARK = 8'hFF;

    // result kinds
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_BAD_ID = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME0_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME1_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME2_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME0_SIZES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME1_SIZES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME2_SIZES = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE        = 3'd7;

    typedef enum logic [1:0] {SEEK_MARK, READ_ID, READ_TIME, READ_VARS} t_parse_phase;

    typedef struct {
        logic        kind;
        logic [7:0]  frame_number;
        logic [4:0]  var_index;
        logic [31:0] value;
        logic [35:0] timestamp;
        logic        last_of_frame;
    } t_var_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    logic [7:0]            i_rx_byte   = 8'd0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic                  o_kind;
    logic [7:0]            o_frame_number;
    logic [4:0]            o_var_index;
    logic [31:0]           o_value;
    logic [35:0]           o_timestamp;
    logic                  o_last_of_frame;

    // stimulus and expectations
    logic [7:0]  rx_stream[$];
    t_var_result expected_vars[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_mode = 0;

    // long pop hold-off requests, taken up by the monitor
    int unsigned pop_hold_req = 0;
    int unsigned pop_hold_seen = 0;
    int unsigned pop_hold_left = 0;

    // shadow of the configuration registers
    logic        log_on = 1'b0;
    logic [5:0]  var_count[3] = '{default: '0};
    logic [63:0] var_sizes[3] = '{default: '0};

    // parser state of the model
    t_parse_phase phase     = SEEK_MARK;
    logic         halted    = 1'b0;
    logic [1:0]   byte_cnt  = '0;
    logic [4:0]   var_pos   = '0;
    logic [1:0]   cur_frame = '0;
    logic [31:0]  time_acc  = '0;
    logic [31:0]  value_acc = '0;

    log_frame_deframer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_frame_number  (o_frame_number),
        .o_var_index     (o_var_index),
        .o_value         (o_value),
        .o_timestamp     (o_timestamp),
        .o_last_of_frame (o_last_of_frame)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // appends one byte to the pending stimulus
    function automatic void queue_byte(input logic [7:0] b);
        rx_stream.insert(rx_stream.size(), b);
    endfunction

    // appends one predicted result
    function automatic void queue_result(input t_var_result r);
        expected_vars.insert(expected_vars.size(), r);
    endfunction

    // variables in a frame, 0 when the id is unconfigured
    function automatic int unsigned frame_vars(input logic [7:0] f);
        int unsigned c;
        if (f >= FRAME_COUNT) return 0;
        c = var_count[f];
        return (c > MAX_VARS) ? MAX_VARS : c;
    endfunction

    function automatic void clear_parser();
        phase     = SEEK_MARK;
        byte_cnt  = '0;
        var_pos   = '0;
        value_acc = '0;
    endfunction

    // one received byte through the parser model
    function automatic void deframe_byte(input logic [7:0] b);
        t_var_result r;
        logic [1:0]  end_cnt;
        if (!log_on || halted) begin
            clear_parser();
            return;
        end
        case (phase)
            SEEK_MARK: begin
                if (b == START_MARK) phase = READ_ID;
            end
            READ_ID: begin
                if (frame_vars(b) == 0) begin
                    r = '{default: '0};
                    r.kind = KIND_BAD_ID;
                    r.frame_number = b;
                    queue_result(r);
                    clear_parser();
                    halted = 1'b1;
                end else begin
                    cur_frame = b[1:0];
                    time_acc  = '0;
                    byte_cnt  = '0;
                    phase     = READ_TIME;
                end
            end
            READ_TIME: begin
                time_acc = {time_acc[23:0], b};
                byte_cnt = byte_cnt + 2'd1;
                if (byte_cnt == 2'd0) begin
                    phase     = READ_VARS;
                    var_pos   = '0;
                    value_acc = '0;
                end
            end
            default: begin
                if (byte_cnt == 2'd0) value_acc = '0;
                value_acc = {value_acc[23:0], b};
                end_cnt = var_sizes[cur_frame][2*var_pos +: 2] + 2'd1;
                byte_cnt = byte_cnt + 2'd1;
                if (byte_cnt == end_cnt) begin
                    r.kind          = KIND_VALUE;
                    r.frame_number  = {6'd0, cur_frame};
                    r.var_index     = var_pos;
                    r.value         = value_acc;
                    r.timestamp     = {4'd0, time_acc} * 36'd10;
                    r.last_of_frame = (int'(var_pos) + 1 >= frame_vars({6'd0, cur_frame}));
                    queue_result(r);
                    byte_cnt = '0;
                    if (r.last_of_frame) begin
                        phase   = READ_ID;
                        var_pos = '0;
                    end else begin
                        var_pos = var_pos + 5'd1;
                    end
                end
            end
        endcase
    endfunction

    // waits until no byte and no result is outstanding, then lets the parser settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (rx_stream.size() != 0 || push || expected_vars.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, mirrored into the shadow copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LOG_ENABLE: begin
                log_on = data[0];
                halted = 1'b0;
                if (!data[0]) clear_parser();
            end
            REG_FRAME0_COUNT, REG_FRAME1_COUNT, REG_FRAME2_COUNT:
                var_count[idx - REG_FRAME0_COUNT] = data[5:0];
            REG_FRAME0_SIZES, REG_FRAME1_SIZES, REG_FRAME2_SIZES:
                var_sizes[idx - REG_FRAME0_SIZES] = data;
            default: ;
        endcase
    endtask

    // new variable counts and sizes for all three frames, extremes included
    task automatic randomize_frames();
        int unsigned sel;
        logic [5:0]  cnt;
        logic [63:0] sz;
        for (int f = 0; f < 3; f++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) cnt = 6'd0;
            else if (sel <= 7) cnt = 6'($urandom_range(1, 4));
            else if (sel == 8) cnt = 6'($urandom_range(5, 32));
            else cnt = 6'($urandom_range(33, 63));
            sel = $urandom_range(0, 3);
            if (sel == 0) sz = '0;
            else if (sel == 1) sz = '1;
            else sz = {$urandom, $urandom};
            write_reg(CFG_IDX_W'(REG_FRAME0_COUNT + f), {58'd0, cnt});
            write_reg(CFG_IDX_W'(REG_FRAME0_SIZES + f), sz);
        end
    endtask

    // a configured frame id, or -1 when none is configured
    function automatic int pick_frame();
        int f;
        if (var_count[0] == 0 && var_count[1] == 0 && var_count[2] == 0) return -1;
        do f = $urandom_range(0, 2); while (var_count[f] == 0);
        return f;
    endfunction

    // queues one frame with random content, optionally cut short; returns bytes queued
    function automatic int add_frame(input logic [1:0] f, input bit cut);
        logic [7:0]  frame_bytes[$];
        int unsigned ts_sel;
        int unsigned keep;
        logic [1:0]  size_code;
        frame_bytes.insert(frame_bytes.size(), {6'd0, f});
        ts_sel = $urandom_range(0, 7);
        repeat (4) begin
            frame_bytes.insert(frame_bytes.size(),
                               ts_sel == 0 ? 8'h00 : ts_sel == 1 ? 8'hFF : rand_byte());
        end
        for (int i = 0; i < frame_vars({6'd0, f}); i++) begin
            size_code = var_sizes[f][2*i +: 2];
            repeat (int'(size_code) + 1) frame_bytes.insert(frame_bytes.size(), rand_byte());
        end
        keep = cut ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
        for (int i = 0; i < keep; i++) queue_byte(frame_bytes[i]);
        return keep;
    endfunction

    // byte driver: holds a request while full, predicts on each accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push) deframe_byte(i_rx_byte);
            if (rx_stream.size() != 0 && $urandom_range(0, 99) >=
                    (idle_mode == 0 ? IDLE_LO : idle_mode == 1 ? IDLE_HI : 0)) begin
                push      <= 1'b1;
                i_rx_byte <= rx_stream.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result monitor with random and long pop hold-offs
    always @(posedge i_clk) begin
        t_var_result exp_r;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_vars.size() == 0) begin
                    $error("result with no request waiting: kind %0d frame %0d index %0d",
                           o_kind, o_frame_number, o_var_index);
                    fail_count++;
                end else begin
                    exp_r = expected_vars.pop_front();
                    if (o_kind !== exp_r.kind) begin
                        $error("kind: expected %0d, actual %0d", exp_r.kind, o_kind);
                        fail_count++;
                    end
                    if (o_frame_number !== exp_r.frame_number) begin
                        $error("frame_number: expected %0d, actual %0d",
                               exp_r.frame_number, o_frame_number);
                        fail_count++;
                    end
                    if (o_var_index !== exp_r.var_index) begin
                        $error("var_index: expected %0d, actual %0d",
                               exp_r.var_index, o_var_index);
                        fail_count++;
                    end
                    if (o_value !== exp_r.value) begin
                        $error("value: expected 0x%08h, actual 0x%08h", exp_r.value, o_value);
                        fail_count++;
                    end
                    if (o_timestamp !== exp_r.timestamp) begin
                        $error("timestamp: expected 0x%09h, actual 0x%09h",
                               exp_r.timestamp, o_timestamp);
                        fail_count++;
                    end
                    if (o_last_of_frame !== exp_r.last_of_frame) begin
                        $error("last_of_frame: expected %0d, actual %0d",
                               exp_r.last_of_frame, o_last_of_frame);
                        fail_count++;
                    end
                end
            end
            if (pop_hold_req != pop_hold_seen) begin
                pop_hold_seen = pop_hold_req;
                pop_hold_left = HOLD_CYCLES;
            end
            if (pop_hold_left != 0) begin
                pop_hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >=
                        (idle_mode == 0 ? IDLE_HI : idle_mode == 1 ? IDLE_LO : 0));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned random_sent;
        int unsigned budget;
        int unsigned sent;
        int unsigned tail;
        int unsigned extra;
        int          f;
        logic [7:0]  bad_id;
        bit          pressure_done;
        random_sent   = 0;
        pressure_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // directed: frame table, bytes while disabled are dropped
        write_reg(REG_SPARE, '1);
        write_reg(REG_FRAME0_COUNT, 64'd2);
        write_reg(REG_FRAME0_SIZES, 64'h3);
        write_reg(REG_FRAME1_COUNT, 64'd63);
        write_reg(REG_FRAME1_SIZES, 64'd0);
        write_reg(REG_FRAME2_COUNT, 64'd0);
        write_reg(REG_FRAME2_SIZES, '1);
        rx_stream = '{START_MARK, 8'h00};
        wait_idle();

        // directed: noise before marker, max timestamp and value, back-to-back frames
        write_reg(REG_LOG_ENABLE, 64'd1);
        rx_stream = '{8'h5A, START_MARK, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                      8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80};
        wait_idle();

        // directed: count lowered mid-frame ends it, then unconfigured id halts
        write_reg(REG_FRAME1_COUNT, 64'd1);
        rx_stream = '{8'h7F, 8'h02, 8'h33};
        wait_idle();

        // directed: id past the frame range, then marker value as id
        write_reg(REG_LOG_ENABLE, 64'd1);
        rx_stream = '{START_MARK, 8'h03};
        wait_idle();
        write_reg(REG_LOG_ENABLE, 64'd1);
        rx_stream = '{START_MARK, START_MARK};

        // random frame streams in chunks
        while (random_sent < RANDOM_ITEMS) begin
            idle_mode = (random_sent < RANDOM_ITEMS / 3) ? 0 :
                        (random_sent < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
            wait_idle();

            // back-pressure: one-byte variables while pop is held off
            if (idle_mode == 2 && !pressure_done) begin
                pressure_done = 1'b1;
                write_reg(REG_FRAME0_COUNT, 64'd32);
                write_reg(REG_FRAME0_SIZES, 64'd0);
                write_reg(REG_LOG_ENABLE, 64'd0);
                write_reg(REG_LOG_ENABLE, 64'd1);
                pop_hold_req++;
                queue_byte(START_MARK);
                random_sent += 1 + add_frame(2'd0, 1'b0);
                continue;
            end

            if ($urandom_range(0, 1)) randomize_frames();
            write_reg(REG_LOG_ENABLE, 64'd0);

            // occasionally a stretch of bytes while disabled
            if ($urandom_range(0, 19) == 0) begin
                repeat (6) queue_byte(rand_byte());
                random_sent += 6;
                continue;
            end
            write_reg(REG_LOG_ENABLE, 64'd1);

            sent = 0;
            if ($urandom_range(0, 3) == 0) begin
                extra = $urandom_range(1, 3);
                repeat (extra) queue_byte(8'($urandom_range(0, 254)));
                sent += extra;
            end
            queue_byte(START_MARK);
            budget = $urandom_range(20, 60);
            sent++;
            f = pick_frame();
            while (f >= 0 && sent < budget) begin
                sent += add_frame(f[1:0], 1'b0);
                f = pick_frame();
            end

            // chunk ending: clean, truncated frame, or bad id followed by dropped bytes
            tail = $urandom_range(0, 9);
            if (tail >= 8 || f < 0) begin
                bad_id = 8'($urandom_range(3, 255));
                for (int k = 0; k < 3; k++) begin
                    if (var_count[k] == 0 && $urandom_range(0, 1)) bad_id = 8'(k);
                end
                queue_byte(bad_id);
                sent++;
                extra = $urandom_range(1, 3);
                repeat (extra) queue_byte(rand_byte());
                sent += extra;
            end else if (tail >= 6) begin
                sent += add_frame(f[1:0], 1'b1);
            end
            random_sent += sent;
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/lfd_pkg.sv
design/lfd_front.sv
design/lfd_queue.sv
design/lfd_back.sv
design/log_frame_deframer.sv
tb/sv/tb_top.sv
